// ===== design/multi_reader_ring_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Multi-reader ring buffer: assertion macros
// Shared immediate-cycle and next-cycle property macros for the design files.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_RING_BUFFER_DEFINES_SVH
`define MULTI_READER_RING_BUFFER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-reader ring buffer package
// Item types, action and status codes, and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam int DEF_BUF_DEPTH    = 1024;
    localparam int DEF_READER_SLOTS = 4;
    localparam int DEF_MAX_READ     = 64;

    localparam int ACT_W  = 3;
    localparam int HDL_W  = 3;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 7;
    localparam int STS_W  = 3;
    localparam int PEND_W = 10;

    localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_OPEN  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COUNT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 3'd5;

    localparam logic [STS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STS_W-1:0] ST_BAD_HANDLE  = 3'd1;
    localparam logic [STS_W-1:0] ST_CLOSED      = 3'd2;
    localparam logic [STS_W-1:0] ST_NO_SLOT     = 3'd3;
    localparam logic [STS_W-1:0] ST_DROPPED     = 3'd4;
    localparam logic [STS_W-1:0] ST_UNSUPPORTED = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [HDL_W-1:0]  reader_handle;
        logic [BYTE_W-1:0] data_byte;
        logic [REQ_W-1:0]  request_len;
    } t_in_item;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [BYTE_W-1:0] read_byte;
        logic              byte_valid;
        logic [HDL_W-1:0]  opened_handle;
        logic [PEND_W-1:0] pending_count;
        logic              last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic exec;        // carry out a single-result item
        logic start_read;  // latch slot and head for a multi-byte read
        logic emit_byte;   // hand out the byte at the working pointer
        logic byte_last;   // that byte closes the read
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;       // output register can take a result
        logic read_has_data;  // handle good, slot open, bytes pending
        logic ptr_next_at_wp; // working pointer is one short of the tail
    } t_dp_status;

endpackage

// ===== design/mrrb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mrrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multi-reader ring buffer controller
// Accepts items and sequences multi-byte reads, one byte per free output slot.
// ----------------------------------------------------------------------------
`include "multi_reader_ring_buffer_defines.svh"

module mrrb_ctrl import mrrb_pkg::*; #(
    parameter int MAX_READ = DEF_MAX_READ
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    input  logic [REQ_W-1:0] i_request_len,
    input  t_dp_status       i_status,
    output logic             o_in_ready,
    output t_dp_cmd          o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam logic [REQ_W-1:0] MAX_REQ = REQ_W'(MAX_READ);

    logic             r_state, n_state;
    logic [REQ_W-1:0] r_rem, n_rem;
    logic [REQ_W-1:0] req_sat;
    logic             accept;

    assign req_sat    = (i_request_len > MAX_REQ) ? MAX_REQ : i_request_len;
    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_rem      = r_rem;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_action == ACT_READ) && (req_sat != '0) &&
                        i_status.read_has_data) begin
                        o_cmd.start_read = 1'b1;
                        n_rem            = req_sat;
                        n_state          = S_READ;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.byte_last = (r_rem == REQ_W'(1)) || i_status.ptr_next_at_wp;
                if (i_status.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    n_rem           = r_rem - REQ_W'(1);
                    if (o_cmd.byte_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
        end
    end

    `MRRB_ASSERT_NOW(a_read_has_budget, i_clk, i_rst_n, r_state == S_READ, r_rem != '0, "read state with no bytes left")
    `MRRB_ASSERT_NEXT(a_start_enters_read, i_clk, i_rst_n, o_cmd.start_read, r_state == S_READ, "read start did not enter read state")
    `MRRB_ASSERT_NEXT(a_last_leaves_read, i_clk, i_rst_n, o_cmd.emit_byte && o_cmd.byte_last, r_state == S_IDLE, "final byte did not end the read")

endmodule

// ===== design/mrrb_dp.sv =====
// ----------------------------------------------------------------------------
// Multi-reader ring buffer datapath
// Byte store, write and read pointers, slot table and output register.
// ----------------------------------------------------------------------------
`include "multi_reader_ring_buffer_defines.svh"

module mrrb_dp import mrrb_pkg::*; #(
    parameter int BUF_DEPTH    = DEF_BUF_DEPTH,
    parameter int READER_SLOTS = DEF_READER_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_in_item,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    localparam int PW = $clog2(BUF_DEPTH);
    localparam int SW = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
    localparam int CW = $clog2(READER_SLOTS + 1);
    localparam int HX = 5;

    localparam logic [PW-1:0] LAST_IDX = PW'(BUF_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X  = (PW+1)'(BUF_DEPTH);
    localparam logic [HX-1:0] SLOTS_X  = HX'(READER_SLOTS);

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        adv = (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp [READER_SLOTS];
    logic [PW-1:0]     n_rp [READER_SLOTS];
    logic              r_open [READER_SLOTS];
    logic              n_open [READER_SLOTS];
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [SW-1:0]     r_slot, n_slot;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [HX-1:0]     h_x;
    logic              h_ok;
    logic [SW-1:0]     h_idx;
    logic              sel_open;
    logic [PW-1:0]     head;
    logic              free_found;
    logic [SW-1:0]     free_idx;
    logic [PW:0]       pend;
    logic [BYTE_W-1:0] ram_q;
    logic              ram_we;
    logic              out_free;
    logic [READER_SLOTS-1:0] open_bits;

    assign h_x      = HX'(i_in_item.reader_handle);
    assign h_ok     = (h_x != '0) && (h_x <= SLOTS_X);
    assign h_idx    = SW'(h_x - HX'(1));
    assign sel_open = r_open[h_idx];
    assign head     = r_rp[h_idx];
    assign out_free = !r_out_valid || i_out_ready;

    // Pending bytes, modulo the store depth
    assign pend = (r_wp >= head) ? ({1'b0, r_wp} - {1'b0, head})
                                 : ({1'b0, r_wp} + DEPTH_X - {1'b0, head});

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = READER_SLOTS - 1; j >= 0; j--) begin
            if (!r_open[j]) begin
                free_found = 1'b1;
                free_idx   = SW'(j);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < READER_SLOTS; j++) begin
            open_bits[j] = r_open[j];
        end
    end

    assign o_status.out_free       = out_free;
    assign o_status.read_has_data  = h_ok && sel_open && (head != r_wp);
    assign o_status.ptr_next_at_wp = (adv(r_rd_ptr) == r_wp);

    assign ram_we = i_cmd.exec && (i_in_item.action == ACT_PUSH) && (r_cnt != '0);

    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_open      = r_open;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_rd_ptr    = r_rd_ptr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cmd.exec) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.last  = 1'b1;
            unique case (i_in_item.action)
                ACT_PUSH: begin
                    if (r_cnt == '0) begin
                        n_out.status = ST_DROPPED;
                    end else begin
                        n_out.status = ST_OK;
                        n_wp         = adv(r_wp);
                    end
                end
                ACT_OPEN: begin
                    if (!free_found) begin
                        n_out.status = ST_NO_SLOT;
                    end else begin
                        n_out.status        = ST_OK;
                        n_out.opened_handle = HDL_W'(int'(free_idx) + 1);
                        n_open[free_idx]    = 1'b1;
                        n_cnt               = r_cnt + CW'(1);
                        // First open restarts the tail at zero
                        if (r_cnt == '0) begin
                            n_wp             = '0;
                            n_rp[free_idx]   = '0;
                        end else begin
                            n_rp[free_idx]   = r_wp;
                        end
                    end
                end
                ACT_READ, ACT_CLEAR, ACT_COUNT, ACT_CLOSE: begin
                    if (!h_ok) begin
                        n_out.status = ST_BAD_HANDLE;
                    end else if (!sel_open) begin
                        n_out.status = ST_CLOSED;
                    end else begin
                        n_out.status = ST_OK;
                        if (i_in_item.action == ACT_CLEAR) begin
                            n_rp[h_idx] = r_wp;
                        end else if (i_in_item.action == ACT_COUNT) begin
                            n_out.pending_count = PEND_W'(pend);
                        end else if (i_in_item.action == ACT_CLOSE) begin
                            n_open[h_idx] = 1'b0;
                            n_rp[h_idx]   = '0;
                            n_cnt         = r_cnt - CW'(1);
                            // Last close restarts the tail at zero
                            if (r_cnt == CW'(1)) begin
                                n_wp = '0;
                            end
                        end
                    end
                end
                default: begin
                    n_out.status = ST_UNSUPPORTED;
                end
            endcase
        end

        if (i_cmd.start_read) begin
            n_slot   = h_idx;
            n_rd_ptr = head;
        end

        if (i_cmd.emit_byte) begin
            n_out_valid      = 1'b1;
            n_out            = '0;
            n_out.status     = ST_OK;
            n_out.read_byte  = ram_q;
            n_out.byte_valid = 1'b1;
            n_out.last       = i_cmd.byte_last;
            n_rd_ptr         = adv(r_rd_ptr);
            n_rp[r_slot]     = adv(r_rd_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < READER_SLOTS; k++) begin
                r_rp[k]   <= '0;
                r_open[k] <= 1'b0;
            end
        end else begin
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_rp        <= n_rp;
            r_open      <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_rd_ptr <= n_rd_ptr;
        r_out    <= n_out;
    end

    // Read address runs one step ahead so the registered data matches r_rd_ptr
    mrrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_in_item.data_byte),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `MRRB_ASSERT_NOW(a_count_matches_slots, i_clk, i_rst_n, 1'b1, r_cnt == CW'($countones(open_bits)), "open count out of step with slot table")
    `MRRB_ASSERT_NOW(a_tail_zero_when_idle, i_clk, i_rst_n, r_cnt == '0, r_wp == '0, "tail moved with no reader open")
    `MRRB_ASSERT_NOW(a_byte_only_ok, i_clk, i_rst_n, r_out_valid && r_out.byte_valid, r_out.status == ST_OK, "byte result with error status")

endmodule

// ===== design/multi_reader_ring_buffer.sv =====
// A single-result item shows its result in the cycle after acceptance; such
// items go one per cycle while the output is taken. A read first latches slot
// and head, then registers each byte into the output register, one byte per
// cycle while the output is taken; the block takes no item until the last byte.
// Reset (synchronous, active low) clears pointers, slot table and open count;
// the byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Multi-reader ring buffer
// Shared receive ring with one tail and a head per reader slot.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer import mrrb_pkg::*; #(
    parameter int BUF_DEPTH    = DEF_BUF_DEPTH,
    parameter int READER_SLOTS = DEF_READER_SLOTS,
    parameter int MAX_READ     = DEF_MAX_READ
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Command and status between the sequencer and the datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer: decide acceptance, start reads, pace byte output
    mrrb_ctrl #(
        .MAX_READ (MAX_READ)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_action      (i_in_item.action),
        .i_request_len (i_in_item.request_len),
        .i_status      (dp_status),
        .o_in_ready    (o_in_ready),
        .o_cmd         (dp_cmd)
    );

    // Datapath: hold the store, pointers and slots; register every result
    mrrb_dp #(
        .BUF_DEPTH    (BUF_DEPTH),
        .READER_SLOTS (READER_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_item   (i_in_item),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
